>>> rtl/swcc_pkg.sv
`default_nettype none
package swcc_pkg;
	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int TMR_W = 19;
	localparam int LEN_W = 9;

	typedef enum logic [1:0] {
		OP_SEND = 2'd0,
		OP_ACK = 2'd1,
		OP_TICK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_FULL = 3'd1,
		ST_NEW_ACK = 3'd2,
		ST_DUP_ACK = 3'd3,
		ST_RANGE = 3'd4,
		ST_RESEND = 3'd5,
		ST_NO_EXPIRY = 3'd6
	} status_t;

	localparam logic [1:0] REG_MAX_WINDOW = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_INIT_THRESH = 2'd2;
	localparam logic [1:0] REG_INIT_WINDOW = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SLIDE,
		S_SCAN,
		S_SCAN_WR,
		S_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic slide;
		logic scan_rd;
		logic scan_wr;
		logic emit;
		logic emit_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t op;
		logic need_slide;
		logic scan_done;
		logic scan_hit;
		logic any_resend;
	} sts_t;
endpackage
`default_nettype wire

>>> rtl/swcc_ram.sv
`default_nettype none
module swcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/swcc_ctrl.sv
`default_nettype none
module swcc_ctrl import swcc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	output cmd_t cmd,
	input wire sts_t sts
);
	state_t state_q, state_d;
	logic out_done;

	// the result register is free or its transfer completes this cycle
	assign out_done = !out_valid || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				priority if (sts.op == OP_TICK) begin
					state_d = S_SCAN;
				end else if (sts.op == OP_NONE) begin
					state_d = S_IDLE;
				end else if (sts.op == OP_ACK) begin
					state_d = S_SLIDE;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_SLIDE: begin
				if (!sts.need_slide) begin
					state_d = S_EMIT;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_SCAN_WR;
				end
			end
			S_SCAN_WR: begin
				if (sts.scan_hit && sts.any_resend) begin
					if (out_done) begin
						state_d = S_SCAN;
					end
				end else begin
					state_d = S_SCAN;
				end
			end
			S_EMIT: begin
				if (out_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.capture = in_valid;
			end
			S_EXEC: cmd.exec = 1'b1;
			S_SLIDE: cmd.slide = 1'b1;
			S_SCAN: cmd.scan_rd = !sts.scan_done;
			S_SCAN_WR: begin
				// a new hit pushes out the held resend first
				if (sts.scan_hit && sts.any_resend) begin
					if (out_done) begin
						cmd.scan_wr = 1'b1;
						cmd.emit = 1'b1;
					end
				end else begin
					cmd.scan_wr = 1'b1;
				end
			end
			S_EMIT: begin
				if (out_done) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

>>> rtl/swcc_dp.sv
`default_nettype none
module swcc_dp import swcc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [1:0] operation,
	input wire logic [31:0] seq_number,
	input wire logic [8:0] packet_length,
	input wire logic lost,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [18:0] cfg_data,
	input wire cmd_t cmd,
	output sts_t sts,
	input wire logic out_stall,
	output logic out_valid,
	output logic [2:0] status,
	output logic [31:0] packet_seq,
	output logic [8:0] resend_length,
	output logic [31:0] window_base,
	output logic [15:0] window_size,
	output logic [15:0] slow_start_limit,
	output logic last
);
	logic [15:0] max_window_q;
	logic [18:0] timeout_q;
	logic [31:0] base_q, next_q;
	logic [OCC_W-1:0] occ_q;
	logic [15:0] cwnd_q, ssth_q;
	logic [DEPTH-1:0] acked_q;
	// physical slot of window entry k is (head_q + k) mod DEPTH
	logic [IDX_W-1:0] head_q;

	logic [1:0] op_q;
	logic [31:0] seq_q;
	logic [8:0] len_q;
	logic lost_q;
	status_t res_st_q;
	logic [31:0] res_seq_q;
	logic [8:0] res_len_q;

	logic [OCC_W-1:0] scan_k_q;
	logic [5:0] resend_n_q;
	logic [IDX_W-1:0] scan_slot_q;

	logic [18:0] tmr_rd;
	logic [8:0] len_rd;
	logic tmr_we;
	logic [IDX_W-1:0] tmr_wa, tmr_ra;
	logic [18:0] tmr_wd;

	logic [31:0] diff;
	logic [IDX_W-1:0] d_slot, tail_slot, k_slot;
	logic [16:0] cwnd2;
	logic can_send, hit, cap_ok;

	assign diff = seq_q - base_q;
	assign d_slot = head_q + diff[IDX_W-1:0];
	assign tail_slot = head_q + occ_q[IDX_W-1:0];
	assign k_slot = head_q + scan_k_q[IDX_W-1:0];
	assign cwnd2 = {cwnd_q, 1'b0};
	assign can_send = ({{(16-OCC_W){1'b0}}, occ_q} < cwnd_q)
		&& (occ_q < OCC_W'(DEPTH));
	assign cap_ok = resend_n_q < 6'd32;
	assign hit = !acked_q[scan_slot_q] && (tmr_rd <= 19'd1) && cap_ok;

	assign sts.op = op_t'(op_q);
	assign sts.need_slide = (occ_q != '0) && acked_q[head_q];
	assign sts.scan_done = scan_k_q >= occ_q;
	assign sts.scan_hit = hit;
	assign sts.any_resend = resend_n_q != '0;

	// timer store write mux: send loads, scan reloads or decrements
	always_comb begin
		tmr_we = 1'b0;
		tmr_wa = tail_slot;
		tmr_wd = timeout_q;
		tmr_ra = k_slot;
		if (cmd.exec && op_q == OP_SEND && can_send) begin
			tmr_we = 1'b1;
		end else if (cmd.scan_wr && !acked_q[scan_slot_q]) begin
			tmr_wa = scan_slot_q;
			if (tmr_rd <= 19'd1) begin
				tmr_we = cap_ok;
			end else begin
				tmr_we = 1'b1;
				tmr_wd = tmr_rd - 19'd1;
			end
		end
	end

	swcc_ram #(.WIDTH(TMR_W), .DEPTH(DEPTH)) u_tmr (
		.clk(clk), .we(tmr_we), .waddr(tmr_wa), .wdata(tmr_wd),
		.raddr(tmr_ra), .rdata(tmr_rd)
	);
	swcc_ram #(.WIDTH(LEN_W), .DEPTH(DEPTH)) u_len (
		.clk(clk), .we(cmd.exec && op_q == OP_SEND && can_send), .waddr(tail_slot),
		.wdata(len_q), .raddr(tmr_ra), .rdata(len_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= operation;
			seq_q <= seq_number;
			len_q <= packet_length;
			lost_q <= lost;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_window_q <= 16'd32;
			timeout_q <= 19'd300000;
			base_q <= '0;
			next_q <= '0;
			occ_q <= '0;
			cwnd_q <= 16'd2;
			ssth_q <= 16'd50;
			acked_q <= '0;
			head_q <= '0;
			res_st_q <= ST_ACCEPTED;
			res_seq_q <= '0;
			res_len_q <= '0;
			scan_k_q <= '0;
			resend_n_q <= '0;
			scan_slot_q <= '0;
			out_valid <= 1'b0;
			status <= '0;
			packet_seq <= '0;
			resend_length <= '0;
			window_base <= '0;
			window_size <= '0;
			slow_start_limit <= '0;
			last <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_WINDOW: max_window_q <= cfg_data[15:0];
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_INIT_THRESH: ssth_q <= cfg_data[15:0];
					REG_INIT_WINDOW: cwnd_q <= (cfg_data[15:0] == '0) ? 16'd1
						: cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				scan_k_q <= '0;
				resend_n_q <= '0;
				res_len_q <= '0;
				unique case (op_t'(op_q))
					OP_SEND: begin
						if (can_send) begin
							if (lost_q) begin
								ssth_q <= {1'b0, cwnd_q[15:1]};
								cwnd_q <= 16'd1;
							end
							acked_q[tail_slot] <= 1'b0;
							occ_q <= occ_q + 1'b1;
							next_q <= next_q + 1'b1;
							res_st_q <= ST_ACCEPTED;
						end else begin
							res_st_q <= ST_FULL;
						end
						res_seq_q <= next_q;
					end
					OP_ACK: begin
						res_seq_q <= seq_q;
						priority if (diff[31]) begin
							res_st_q <= ST_DUP_ACK;
						end else if (diff >= {{(32-OCC_W){1'b0}}, occ_q}) begin
							res_st_q <= ST_RANGE;
						end else if (acked_q[d_slot]) begin
							res_st_q <= ST_DUP_ACK;
						end else begin
							res_st_q <= ST_NEW_ACK;
							acked_q[d_slot] <= 1'b1;
							priority if (cwnd2 < {1'b0, ssth_q}) begin
								cwnd_q <= cwnd2[15:0];
							end else if (cwnd_q >= ssth_q && cwnd_q < max_window_q) begin
								cwnd_q <= cwnd_q + 16'd1;
							end else if (cwnd_q < ssth_q) begin
								cwnd_q <= ssth_q;
							end else begin
								cwnd_q <= cwnd_q;
							end
						end
					end
					OP_TICK: begin
						res_st_q <= ST_NO_EXPIRY;
						res_seq_q <= '0;
					end
					default: ;
				endcase
			end
			// drop one acked entry at the base
			if (cmd.slide && sts.need_slide) begin
				acked_q[head_q] <= 1'b0;
				head_q <= head_q + 1'b1;
				occ_q <= occ_q - 1'b1;
				base_q <= base_q + 1'b1;
			end
			// scan: read issued, then advance
			if (cmd.scan_rd) begin
				scan_slot_q <= k_slot;
			end
			if (cmd.scan_wr) begin
				scan_k_q <= scan_k_q + 1'b1;
				// hold the newest resend until the next hit or the end of the scan
				if (hit) begin
					resend_n_q <= resend_n_q + 1'b1;
					res_st_q <= ST_RESEND;
					res_seq_q <= base_q + {{(32-OCC_W){1'b0}}, scan_k_q};
					res_len_q <= len_rd;
				end
			end
			// result register: load the held result, else clear after transfer
			if (cmd.emit) begin
				out_valid <= 1'b1;
				window_base <= base_q;
				window_size <= cwnd_q;
				slow_start_limit <= ssth_q;
				status <= res_st_q;
				packet_seq <= res_seq_q;
				resend_length <= res_len_q;
				last <= cmd.emit_last;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/sender_window_congestion_control_top.sv
// A transfer is captured in S_IDLE and run in S_EXEC; a send then goes to
// S_EMIT, an ack slides the base past the acked entries at its head in S_SLIDE,
// then S_EMIT, and a tick scans each entry via S_SCAN (timer read registered)
// and S_SCAN_WR (timer write), then S_EMIT. One item at a time; a stalled result
// holds the controller. Reset (arst_n, asynchronous) empties the window, zeroes
// sequence numbers and loads register defaults; memories are not cleared.
`default_nettype none
module sender_window_congestion_control_top import swcc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] operation,
	input wire logic [31:0] seq_number,
	input wire logic [8:0] packet_length,
	input wire logic lost,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] status,
	output logic [31:0] packet_seq,
	output logic [8:0] resend_length,
	output logic [31:0] window_base,
	output logic [15:0] window_size,
	output logic [15:0] slow_start_limit,
	output logic last,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [18:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	swcc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);
	swcc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .operation(operation), .seq_number(seq_number),
		.packet_length(packet_length), .lost(lost), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
		.out_stall(out_stall), .out_valid(out_valid), .status(status),
		.packet_seq(packet_seq), .resend_length(resend_length),
		.window_base(window_base), .window_size(window_size),
		.slow_start_limit(slow_start_limit), .last(last)
	);
endmodule
`default_nettype wire

>>> rtl/swcc_checker.sv
`default_nettype none
module swcc_checker import swcc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [2:0] status,
	input wire logic [15:0] window_size,
	input wire logic last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed");
	a_win: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> window_size != 16'd0)
		else $error("zero window");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_RESEND |-> last)
		else $error("non-resend result not last");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted while busy");
endmodule

bind sender_window_congestion_control_top swcc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.window_size(window_size), .last(last)
);
`default_nettype wire
